// ===== rtl/core/sitrt_pkg.sv =====
// ----------------------------------------------------------------------------
// sitrt_pkg
// Shared types, constants and helpers for the signed integer to radix text
// converter: radix limits, ASCII codes, job descriptor and back-end states.
// ----------------------------------------------------------------------------
package sitrt_pkg;

   // default width of the converted integer
   localparam int VALUE_BITS_DEF = 32;

   // field widths
   localparam int RADIX_W = 6;
   localparam int CHAR_W  = 7;

   // radix limits and reset value
   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

   // ASCII codes
   localparam logic [CHAR_W-1:0] MINUS_CHAR = 7'h2D;
   localparam logic [CHAR_W-1:0] ZERO_CHAR  = 7'h30;
   localparam logic [CHAR_W-1:0] ALPHA_CHAR = 7'h41;
   localparam logic [CHAR_W-1:0] ERROR_CHAR = 7'h00;

   // job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // control part of one queued job
   typedef struct packed {
      logic [RADIX_W-1:0] radix;
      logic               negative;
      logic               bad_radix;
   } job_ctl_type;

   // back-end sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_LOAD,
      ST_EMIT,
      ST_ERROR
   } back_state_type;

   // digit value to ASCII: 0-9 then A-Z
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] digit);
      logic [CHAR_W-1:0] code;
      if (digit < RADIX_W'(10)) begin
         code = ZERO_CHAR + CHAR_W'(digit);
      end else if (digit < RADIX_MAX) begin
         code = ALPHA_CHAR + CHAR_W'(digit - RADIX_W'(10));
      end else begin
         code = ZERO_CHAR;
      end
      return code;
   endfunction

endpackage

// ===== rtl/core/sitrt_ram.sv =====
// ----------------------------------------------------------------------------
// sitrt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sitrt_ram #(
   parameter int WIDTH  = 6,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/sitrt_front.sv =====
// ----------------------------------------------------------------------------
// sitrt_front
// Accepts words, holds the radix register, classifies each word (radix
// check, sign, magnitude) and queues it as a job for the back end.
// ----------------------------------------------------------------------------
module sitrt_front #(
   parameter int VALUE_BITS = sitrt_pkg::VALUE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [VALUE_BITS-1:0]        value,
   input  logic                         csr_wr_en,
   input  logic [sitrt_pkg::RADIX_W-1:0] csr_wr_data,
   output logic                         job_valid,
   output logic [VALUE_BITS-1:0]        job_mag,
   output sitrt_pkg::job_ctl_type       job_ctl,
   input  logic                         job_pop
);
   import sitrt_pkg::*;

   logic [RADIX_W-1:0]    radix_ff;
   logic [VALUE_BITS-1:0] mag_q_ff [QUEUE_DEPTH];
   job_ctl_type           ctl_q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  push;
   logic                  pop;
   logic                  negative;
   logic [VALUE_BITS-1:0] magnitude;
   job_ctl_type           ctl_new;

   // radix register
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= RADIX_RESET;
      end else if (csr_wr_en) begin
         radix_ff <= csr_wr_data;
      end
   end

   // classify: sign, unsigned magnitude, radix range
   assign negative  = value[VALUE_BITS-1];
   assign magnitude = negative ? (~value + VALUE_BITS'(1)) : value;

   always_comb begin
      ctl_new.radix     = radix_ff;
      ctl_new.negative  = negative;
      ctl_new.bad_radix = (radix_ff < RADIX_MIN) || (radix_ff > RADIX_MAX);
   end

   // queue handshake
   assign busy      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign push      = start && !busy;
   assign job_valid = (count_ff != '0);
   assign pop       = job_pop && job_valid;

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         mag_q_ff[wr_ptr_ff] <= magnitude;
         ctl_q_ff[wr_ptr_ff] <= ctl_new;
      end
   end

   assign job_mag = mag_q_ff[rd_ptr_ff];
   assign job_ctl = ctl_q_ff[rd_ptr_ff];

endmodule

// ===== rtl/core/sitrt_back.sv =====
// ----------------------------------------------------------------------------
// sitrt_back
// Carries out one queued job: repeated radix division by a bit-serial restoring
// divider into the digit store, then emission of the sign and the digits, most
// significant first, through a registered output, or one bad-radix error result.
// ----------------------------------------------------------------------------
module sitrt_back #(
   parameter int VALUE_BITS = sitrt_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  logic [VALUE_BITS-1:0]         job_mag,
   input  sitrt_pkg::job_ctl_type        job_ctl,
   output logic                          job_pop,
   output logic                          rsp_valid,
   output logic [sitrt_pkg::CHAR_W-1:0]  rsp_character,
   output logic                          rsp_last,
   output logic                          rsp_bad_radix
);
   import sitrt_pkg::*;

   localparam int ADDR_W = $clog2(VALUE_BITS);
   localparam int CNT_W  = $clog2(VALUE_BITS + 1);

   back_state_type        state_ff, state_in;
   job_ctl_type           ctl_ff, ctl_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [RADIX_W-1:0]    rem_ff, rem_in;
   logic [ADDR_W-1:0]     bit_ff, bit_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;

   // divider step
   logic [RADIX_W:0]      trial;
   logic                  quo_bit;
   logic [RADIX_W-1:0]    rem_step;
   logic [VALUE_BITS-1:0] mag_step;
   logic                  last_bit;
   logic                  div_done;

   // digit store ports
   logic                  st_wr_en;
   logic [ADDR_W-1:0]     st_wr_addr;
   logic [ADDR_W-1:0]     st_rd_addr;
   logic [RADIX_W-1:0]    st_rd_data;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_bad_ff, rsp_bad_in;

   // one restoring division bit per cycle
   assign trial    = {rem_ff, mag_ff[VALUE_BITS-1]};
   assign quo_bit  = (trial >= {1'b0, ctl_ff.radix});
   assign rem_step = quo_bit ? RADIX_W'(trial - {1'b0, ctl_ff.radix}) : RADIX_W'(trial);
   assign mag_step = {mag_ff[VALUE_BITS-2:0], quo_bit};
   assign last_bit = (bit_ff == ADDR_W'(VALUE_BITS - 1));
   assign div_done = (mag_step == '0) || (cnt_ff + 1'b1 == CNT_W'(VALUE_BITS));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = job_ctl.bad_radix ? ST_ERROR : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (last_bit && div_done) begin
               state_in = ctl_ff.negative ? ST_SIGN : ST_LOAD;
            end
         end
         ST_SIGN:  state_in = ST_EMIT;
         ST_LOAD:  state_in = ST_EMIT;
         ST_EMIT: begin
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERROR: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      job_pop      = 1'b0;
      ctl_in       = ctl_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      st_wr_en     = 1'b0;
      st_wr_addr   = ADDR_W'(cnt_ff);
      st_rd_addr   = ADDR_W'(cnt_ff - 1'b1);
      rsp_valid_in = 1'b0;
      rsp_char_in  = ERROR_CHAR;
      rsp_last_in  = 1'b0;
      rsp_bad_in   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               ctl_in  = job_ctl;
               mag_in  = job_mag;
               rem_in  = '0;
               bit_in  = '0;
               cnt_in  = '0;
            end
         end
         ST_DIVIDE: begin
            mag_in = mag_step;
            if (last_bit) begin
               // digit complete: store it, start the next one on the quotient
               st_wr_en = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               rem_in   = '0;
               bit_in   = '0;
            end else begin
               rem_in = rem_step;
               bit_in = bit_ff + 1'b1;
            end
         end
         ST_SIGN: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = MINUS_CHAR;
            idx_in       = ADDR_W'(cnt_ff - 1'b1);
         end
         ST_LOAD: begin
            idx_in = ADDR_W'(cnt_ff - 1'b1);
         end
         ST_EMIT: begin
            // show the fetched digit, fetch the next lower one
            rsp_valid_in = 1'b1;
            rsp_char_in  = digit_char(st_rd_data);
            rsp_last_in  = (idx_ff == '0);
            st_rd_addr   = idx_ff - 1'b1;
            idx_in       = idx_ff - 1'b1;
         end
         ST_ERROR: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            rsp_bad_in   = 1'b1;
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ctl_ff      <= ctl_in;
      mag_ff      <= mag_in;
      rem_ff      <= rem_in;
      bit_ff      <= bit_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_bad_ff  <= rsp_bad_in;
   end

   // digit store, least significant digit at address 0
   sitrt_ram #(
      .WIDTH (RADIX_W),
      .DEPTH (VALUE_BITS)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (rem_step),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_bad_radix = rsp_bad_ff;

endmodule

// ===== rtl/core/signed_integer_to_radix_text.sv =====
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// Converts a signed integer to ASCII text in radix 2 to 36, one character
// per result strobe.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; up to two words queue
// ahead of the converter. Each word yields an optional '-' and then its digits,
// most significant first, one character per rsp_valid cycle, with rsp_last on
// the final one. The receiver cannot stall: every strobe is a delivered
// character. An out-of-range radix gives one result with rsp_bad_radix set and
// character 0. Each digit comes from a bit-serial division over all VALUE_BITS
// bits, and a minus sign adds no time, since the sign is sent in the cycle that
// fetches the first digit (32-bit decimal: at most 10 digits; radix 2: up to 32
// digits). The user must write the radix register with csr_wr_en only while no
// word is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text #(
   parameter int VALUE_BITS = sitrt_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VALUE_BITS-1:0]  req_value,
   input  logic                          csr_wr_en,
   input  logic [sitrt_pkg::RADIX_W-1:0] csr_wr_data,
   output logic                          rsp_valid,
   output logic [sitrt_pkg::CHAR_W-1:0]  rsp_character,
   output logic                          rsp_last,
   output logic                          rsp_bad_radix
);
   import sitrt_pkg::*;

   logic                  job_valid;
   logic [VALUE_BITS-1:0] job_mag;
   job_ctl_type           job_ctl;
   logic                  job_pop;

   // front end: accept, classify, queue
   sitrt_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .value       (VALUE_BITS'(unsigned'(req_value))),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .job_valid   (job_valid),
      .job_mag     (job_mag),
      .job_ctl     (job_ctl),
      .job_pop     (job_pop)
   );

   // back end: divide and emit
   sitrt_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job_mag       (job_mag),
      .job_ctl       (job_ctl),
      .job_pop       (job_pop),
      .rsp_valid     (rsp_valid),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last),
      .rsp_bad_radix (rsp_bad_radix)
   );

endmodule

// ===== rtl/core/sitrt_checker.sv =====
// ----------------------------------------------------------------------------
// sitrt_checker
// Port-level checks on the radix text converter, bound to the top level.
// ----------------------------------------------------------------------------
module sitrt_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [sitrt_pkg::CHAR_W-1:0]  rsp_character,
   input logic                          rsp_last,
   input logic                          rsp_bad_radix
);
   import sitrt_pkg::*;

   // reset empties the queue and silences the output
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("busy or strobe after reset");

   // an error word is a single result of its own
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_radix) |-> (rsp_last && rsp_character == ERROR_CHAR))
      else $error("bad radix result not a lone zero character");

   // the minus sign is always followed by at least one digit
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_character == MINUS_CHAR) |-> !rsp_last)
      else $error("minus sign marked last");

   // a minus sign is followed directly by a digit, not by a sign or an error
   a_sign_leads: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_character == MINUS_CHAR) |-> ##1 (rsp_valid
         && rsp_character != MINUS_CHAR && !rsp_bad_radix))
      else $error("minus sign not followed by a digit");

endmodule

bind signed_integer_to_radix_text sitrt_checker u_sitrt_checker (
   .clock         (clock),
   .reset         (reset),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last),
   .rsp_bad_radix (rsp_bad_radix)
);

// ===== tb/radix_text_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_text_check_pkg
// Scoreboard for the radix text converter. It keeps its own copy of the radix
// register, works out the character run that each accepted word must produce,
// and compares the characters that come out against that run in order.
// ----------------------------------------------------------------------------
package radix_text_check_pkg;

   import sitrt_pkg::*;

   localparam int VALUE_W      = VALUE_BITS_DEF;
   localparam int REPORT_LIMIT = 10;

   // one character of output text
   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
      logic              bad_radix;
   } text_char_type;

   class radix_text_scoreboard;

      logic [RADIX_W-1:0] radix;
      text_char_type      pending_chars[$];
      int unsigned        mismatch_count;
      string              digit_text;

      function new();
         radix          = RADIX_RESET;
         mismatch_count = 0;
         digit_text     = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
      endfunction

      function void write_radix(input logic [RADIX_W-1:0] new_radix);
         radix = new_radix;
      endfunction

      function int unsigned chars_pending();
         return pending_chars.size();
      endfunction

      // count a failure; only the first few are printed
      function void report(input string msg);
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t mismatch: %s", $time, msg);
         end
      endfunction

      // queue the text of one accepted word
      function void note_value(input logic [VALUE_W-1:0] value);
         logic [VALUE_W-1:0] magnitude;
         logic [RADIX_W-1:0] digits[$];
         text_char_type      ch;
         if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            ch = '{character: ERROR_CHAR, last: 1'b1, bad_radix: 1'b1};
            pending_chars.push_back(ch);
            return;
         end
         // magnitude as unsigned, so the most negative word is fine
         magnitude = value[VALUE_W-1] ? -value : value;
         do begin
            digits.push_front(RADIX_W'(magnitude % VALUE_W'(radix)));
            magnitude = magnitude / VALUE_W'(radix);
         end while (magnitude != '0);
         if (value[VALUE_W-1]) begin
            ch = '{character: MINUS_CHAR, last: 1'b0, bad_radix: 1'b0};
            pending_chars.push_back(ch);
         end
         foreach (digits[i]) begin
            ch.character = CHAR_W'(digit_text[digits[i]]);
            ch.last      = (i == digits.size() - 1);
            ch.bad_radix = 1'b0;
            pending_chars.push_back(ch);
         end
      endfunction

      // compare one delivered character with the oldest one owed
      function void check_char(input text_char_type got);
         text_char_type want;
         if (pending_chars.size() == 0) begin
            report($sformatf("unexpected character %h last %b bad_radix %b",
                             got.character, got.last, got.bad_radix));
            return;
         end
         want = pending_chars.pop_front();
         if (got.character !== want.character) begin
            report($sformatf("character: want %h got %h", want.character, got.character));
         end
         if (got.last !== want.last) begin
            report($sformatf("last: want %b got %b (character %h)",
                             want.last, got.last, want.character));
         end
         if (got.bad_radix !== want.bad_radix) begin
            report($sformatf("bad_radix: want %b got %b (character %h)",
                             want.bad_radix, got.bad_radix, want.character));
         end
      endfunction

      function void check_drained();
         if (pending_chars.size() != 0) begin
            report($sformatf("%0d characters never arrived", pending_chars.size()));
         end
      endfunction

   endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives signed words into the radix text converter under a range of radix
// settings, valid and out of range, with random sender gaps, and checks every
// character strobe against the scoreboard's predicted text.
// ----------------------------------------------------------------------------
module testbench;

   import sitrt_pkg::*;
   import radix_text_check_pkg::*;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_ITEMS  = 240;
   localparam int MAX_GAP       = 11;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT   = 6000;

   localparam logic [RADIX_W-1:0] FIRST_RADIXES [6] = '{
      6'd16, 6'd8, 6'd3, 6'd35, RADIX_MIN, RADIX_MAX
   };

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic signed [VALUE_W-1:0] req_value;
   logic                      csr_wr_en;
   logic [RADIX_W-1:0]        csr_wr_data;
   logic                      rsp_valid;
   logic [CHAR_W-1:0]         rsp_character;
   logic                      rsp_last;
   logic                      rsp_bad_radix;

   radix_text_scoreboard text_sb;
   int unsigned          quiet_cycles = 0;

   signed_integer_to_radix_text #(
      .VALUE_BITS(VALUE_W)
   ) u_top (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_value    (req_value),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .rsp_valid    (rsp_valid),
      .rsp_character(rsp_character),
      .rsp_last     (rsp_last),
      .rsp_bad_radix(rsp_bad_radix)
   );

   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // monitor: radix writes, accepted words, delivered characters
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) begin
            text_sb.write_radix(csr_wr_data);
         end
         if (start && !busy) begin
            text_sb.note_value(req_value);
         end
         if (rsp_valid) begin
            text_sb.check_char(text_char_type'{rsp_character, rsp_last, rsp_bad_radix});
         end
      end
   end

   // watchdog: too long with no word taken and no character out
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // present one word, hold it until taken, then idle for the gap given
   task automatic send_word(input logic [VALUE_W-1:0] value, input int unsigned gap);
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      @(negedge clock);
      if (gap != 0) begin
         start     <= 1'b0;
         req_value <= $urandom;
         repeat (gap) @(negedge clock);
      end
   endtask

   // stop sending until every owed character has come out
   task automatic drain();
      start <= 1'b0;
      while (text_sb.chars_pending() != 0) @(negedge clock);
   endtask

   task automatic write_radix_reg(input logic [RADIX_W-1:0] new_radix);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= new_radix;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int unsigned draw_gap();
      return $urandom_range(0, MAX_GAP);
   endfunction

   // random word: full range, small, extremes, powers of the radix, short
   function automatic logic [VALUE_W-1:0] pick_value(input logic [RADIX_W-1:0] radix);
      logic [63:0]        power;
      logic [VALUE_W-1:0] value;
      int unsigned        steps;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: value = $urandom;
         4: value = $urandom_range(0, 40);
         5: begin
            case ($urandom_range(0, 3))
               0:       value = 32'h8000_0000;
               1:       value = 32'h7FFF_FFFF;
               2:       value = '0;
               default: value = 32'hFFFF_FFFF;
            endcase
         end
         6, 7: begin
            // digit count boundary: radix^k or radix^k - 1
            power = 64'd1;
            steps = $urandom_range(1, 31);
            while (steps != 0 && radix >= RADIX_MIN && power * radix <= 64'h8000_0000) begin
               power = power * radix;
               steps--;
            end
            value = VALUE_W'(power) - VALUE_W'($urandom_range(0, 1));
         end
         default: value = $urandom >> $urandom_range(0, 31);
      endcase
      if (!value[VALUE_W-1] && $urandom_range(0, 2) == 0) begin
         value = -value;
      end
      return value;
   endfunction

   initial begin
      logic [RADIX_W-1:0] phase_radix;
      int unsigned        phase;
      int unsigned        phase_len;
      int unsigned        gap_mode;
      int unsigned        random_sent;
      text_sb     = new();
      reset       = 1'b1;
      start       = 1'b0;
      req_value   = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = RADIX_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // decimal at the reset radix: zero, single digits, carries, extremes
      send_word(32'd0, draw_gap());
      send_word(32'd1, 0);
      send_word(32'hFFFF_FFFF, 0);
      send_word(32'd9, draw_gap());
      send_word(32'd10, draw_gap());
      send_word(-32'sd10, 0);
      send_word(32'h7FFF_FFFF, draw_gap());
      send_word(32'h8000_0000, 0);
      send_word(32'd1234567890, draw_gap());

      // binary: longest runs
      write_radix_reg(RADIX_MIN);
      send_word(32'h8000_0000, 0);
      send_word(32'h7FFF_FFFF, 0);
      send_word(32'hFFFF_FFFF, draw_gap());
      send_word(32'd0, 0);
      send_word(32'd5, draw_gap());

      // radix 36: letters up to Z
      write_radix_reg(RADIX_MAX);
      send_word(32'd35, 0);
      send_word(32'd36, draw_gap());
      send_word(-32'sd35, 0);
      send_word(32'd1295, draw_gap());
      send_word(32'h8000_0000, 0);
      send_word(32'h7FFF_FFFF, draw_gap());

      // out-of-range radix on both sides
      write_radix_reg(6'd0);
      send_word(32'd7, 0);
      write_radix_reg(6'd63);
      send_word(-32'sd7, 0);
      write_radix_reg(6'd1);
      send_word(32'd0, 0);
      write_radix_reg(6'd37);
      send_word(32'd100, 0);

      // random phases, each at its own radix
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (phase < $size(FIRST_RADIXES)) begin
            phase_radix = FIRST_RADIXES[phase];
         end else if ($urandom_range(0, 5) == 0) begin
            phase_radix = RADIX_W'($urandom_range(0, 63));
         end else begin
            phase_radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
         end
         write_radix_reg(phase_radix);
         phase_len = $urandom_range(8, 24);
         gap_mode  = $urandom_range(0, 2);
         for (int unsigned n = 0; n < phase_len; n++) begin
            if ($urandom_range(0, 19) == 0) begin
               drain();
            end
            send_word(pick_value(phase_radix), gap_mode == 0 ? 0 : draw_gap());
         end
         random_sent += phase_len;
         phase++;
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      text_sb.check_drained();
      if (text_sb.mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/sitrt_pkg.sv
rtl/core/sitrt_ram.sv
rtl/core/sitrt_front.sv
rtl/core/sitrt_back.sv
rtl/core/signed_integer_to_radix_text.sv
rtl/core/sitrt_checker.sv
tb/radix_text_check_pkg.sv
tb/testbench.sv
